### rtl/bknc_pkg.sv
// shared types and constants for the station-keyed name cache
package bknc_pkg;

   localparam int ENTRIES     = 16;
   localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CHUNKS      = 4;
   localparam int CHUNK_W     = 2;
   localparam int NAME_ADDR_W = SLOT_W + CHUNK_W;
   localparam int NAME_DEPTH  = ENTRIES * CHUNKS;
   localparam int MAX_NAME    = 32;
   localparam int LEN_W       = 6;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [47:0]      station_key;
      logic [LEN_W-1:0] name_length;
      logic [1:0]       chunk_number;
      logic [63:0]      chunk_bytes;
      logic             chunk_final;
      logic [31:0]      timestamp;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [1:0]       status;
      logic [LEN_W-1:0] found_length;
      logic [1:0]       out_chunk_number;
      logic [63:0]      out_chunk_bytes;
      logic             run_last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_WRITE,
      S_READ,
      S_LOAD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic               capture;
      logic               scan_en;
      logic [SLOT_W-1:0]  scan_idx;
      logic               write_en;
      logic               commit;
      logic               read_en;
      logic               load_en;
      logic [CHUNK_W-1:0] chunk_idx;
   } ctl_type;

   typedef struct packed {
      logic               needs_scan;
      logic               put_commit;
      logic               get_hit;
      logic [CHUNK_W-1:0] last_chunk;
   } sts_type;

endpackage

### rtl/bknc_ram.sv
// generic single-write, single-read ram with registered read data
module bknc_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bknc_ctrl.sv
// controller state machine for the name cache
module bknc_ctrl
   import bknc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type st,
   output ctl_type ctl
);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               scan_done;
   logic               more_chunks;

   assign scan_done   = (idx_ff == SLOT_W'(ENTRIES - 1));
   assign more_chunks = st.get_hit && (chunk_ff != st.last_chunk);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      chunk_in = chunk_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in   = '0;
            chunk_in = '0;
            if (req_valid) begin
               state_in = st.needs_scan ? S_SCAN : S_RESP;
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (scan_done) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (st.put_commit) begin
               state_in = S_WRITE;
            end else if (st.get_hit) begin
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (more_chunks) begin
                  chunk_in = chunk_ff + 1'b1;
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      ctl           = '0;
      ctl.scan_idx  = idx_ff;
      ctl.chunk_idx = chunk_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         S_SCAN: begin
            ctl.scan_en = 1'b1;
         end
         S_PICK: begin
         end
         S_WRITE: begin
            ctl.write_en = 1'b1;
            ctl.commit   = (chunk_ff == CHUNK_W'(CHUNKS - 1));
         end
         S_READ: begin
            ctl.read_en = 1'b1;
         end
         S_LOAD: begin
            ctl.load_en = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         chunk_ff <= chunk_in;
      end
   end

   // final beat of an item returns to accepting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_ready && !more_chunks) |=> req_ready)
      else $error("ctrl: not ready after last beat");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> ($past(state_ff) == S_READ))
      else $error("ctrl: load without read");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> st.put_commit)
      else $error("ctrl: write outside a commit");

endmodule

### rtl/bknc_dpath.sv
// datapath: slot registers, staging buffer, name memory and result register
module bknc_dpath
   import bknc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  ctl_type ctl,
   output sts_type st,
   output rsp_type rsp_payload
);

   logic [47:0]      key_ff   [ENTRIES];
   logic [31:0]      stamp_ff [ENTRIES];
   logic [LEN_W-1:0] len_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [63:0]      stage_ff [CHUNKS];

   req_type          req_ff;
   rsp_type          rsp_ff;
   logic             match_found_ff;
   logic [SLOT_W-1:0] match_slot_ff;
   logic             have_inv_ff;
   logic [SLOT_W-1:0] inv_slot_ff;
   logic [SLOT_W-1:0] min_slot_ff;
   logic [31:0]      min_stamp_ff;

   logic             bad_len;
   logic [1:0]       first_status;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0] flen;
   logic [LEN_W-1:0] flen_m1;
   logic [NAME_ADDR_W-1:0] wr_addr;
   logic [NAME_ADDR_W-1:0] rd_addr;
   logic [63:0]      wr_data;
   logic [63:0]      rd_data;

   function automatic logic [63:0] keep_bytes(input logic [63:0] v,
                                              input logic [LEN_W-1:0] len,
                                              input logic [CHUNK_W-1:0] chunk);
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] keep;
      logic [63:0]      res;
      start = LEN_W'({chunk, 3'b000});
      keep  = (len > start) ? (len - start) : '0;
      for (int b = 0; b < 8; b++) begin
         res[b*8 +: 8] = (keep > LEN_W'(b)) ? v[b*8 +: 8] : 8'h00;
      end
      return res;
   endfunction

   assign bad_len = (req_payload.name_length == '0) ||
                    (req_payload.name_length > LEN_W'(MAX_NAME));

   always_comb begin
      first_status = STATUS_DONE;
      case (cmd_type'(req_payload.command))
         CMD_PUT: begin
            if (req_payload.chunk_final && bad_len) begin
               first_status = STATUS_REJECT;
            end
         end
         CMD_GET: begin
            first_status = STATUS_LOOKUP;
         end
         default: begin
            first_status = STATUS_DONE;
         end
      endcase
   end

   assign slot    = match_found_ff ? match_slot_ff :
                    (have_inv_ff ? inv_slot_ff : min_slot_ff);
   assign flen    = len_ff[match_slot_ff];
   assign flen_m1 = flen - LEN_W'(1);

   assign st.needs_scan = ((req_payload.command == CMD_PUT) && req_payload.chunk_final &&
                           !bad_len) || (req_payload.command == CMD_GET);
   assign st.put_commit = (req_ff.command == CMD_PUT);
   assign st.get_hit    = (req_ff.command == CMD_GET) && match_found_ff;
   assign st.last_chunk = flen_m1[4:3];

   assign wr_addr = {slot, ctl.chunk_idx};
   assign rd_addr = {match_slot_ff, ctl.chunk_idx};
   assign wr_data = keep_bytes(stage_ff[ctl.chunk_idx], req_ff.name_length, ctl.chunk_idx);

   bknc_ram #(
      .WIDTH  (64),
      .DEPTH  (NAME_DEPTH),
      .ADDR_W (NAME_ADDR_W)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (ctl.write_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.read_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control state: valid marks and staging buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int c = 0; c < CHUNKS; c++) begin
            stage_ff[c] <= '0;
         end
      end else begin
         if (ctl.capture && req_payload.command == CMD_PUT) begin
            stage_ff[req_payload.chunk_number] <= req_payload.chunk_bytes;
         end
         if (ctl.capture && req_payload.command == CMD_CLEAR) begin
            valid_ff <= '0;
         end else if (ctl.commit) begin
            valid_ff[slot] <= 1'b1;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff         <= req_payload;
         match_found_ff <= 1'b0;
         have_inv_ff    <= 1'b0;
         rsp_ff         <= '{hit: 1'b0, status: first_status, found_length: '0,
                             out_chunk_number: '0, out_chunk_bytes: '0, run_last: 1'b1};
      end
      if (ctl.scan_en) begin
         if (valid_ff[ctl.scan_idx] && !match_found_ff &&
             key_ff[ctl.scan_idx] == req_ff.station_key) begin
            match_found_ff <= 1'b1;
            match_slot_ff  <= ctl.scan_idx;
         end
         if (!valid_ff[ctl.scan_idx]) begin
            have_inv_ff <= 1'b1;
            inv_slot_ff <= ctl.scan_idx;
         end
         if (ctl.scan_idx == '0 || stamp_ff[ctl.scan_idx] < min_stamp_ff) begin
            min_stamp_ff <= stamp_ff[ctl.scan_idx];
            min_slot_ff  <= ctl.scan_idx;
         end
      end
      if (ctl.commit) begin
         key_ff[slot]   <= req_ff.station_key;
         len_ff[slot]   <= req_ff.name_length;
         stamp_ff[slot] <= req_ff.timestamp;
      end
      if (ctl.load_en) begin
         rsp_ff <= '{hit: 1'b1, status: STATUS_LOOKUP, found_length: flen,
                     out_chunk_number: ctl.chunk_idx,
                     out_chunk_bytes: keep_bytes(rd_data, flen, ctl.chunk_idx),
                     run_last: (ctl.chunk_idx == st.last_chunk)};
      end
   end

   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (req_ff.command == CMD_PUT) && ctl.write_en)
      else $error("dpath: commit outside a put");

   assert property (@(posedge clock) disable iff (reset)
      ctl.load_en |-> match_found_ff && (req_ff.command == CMD_GET))
      else $error("dpath: load without a hit");

   assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> ($countones(valid_ff) >= 1))
      else $error("dpath: commit left no valid slot");

endmodule

### rtl/bssid_keyed_name_cache_top.sv
// from accept to beat: a put chunk, clear or reject goes straight to the response beat;
// a committing put scans, picks a slot, writes every chunk and responds; a get scans and picks,
// then a miss responds and a hit reads, loads and responds for each beat; one item at a time,
// next accept the cycle after the last beat; the key and stamp scan covers one slot per cycle
// reset: synchronous, clears valid marks and staging buffer; no clearing pass
// top level of the station-keyed name cache
module bssid_keyed_name_cache_top
   import bknc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   ctl_type ctl;
   sts_type st;

   bknc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .ctl       (ctl)
   );

   bknc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .st          (st),
      .rsp_payload (rsp_payload)
   );

endmodule
